### rtl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// Package for the one-pole multimode filter
// Shared state codes, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int unsigned CutoffBits = 17;
  localparam int unsigned RateBits   = 18;
  localparam logic [RateBits-1:0] RateReset = 18'd48000;
  localparam logic [31:0] PiQ30 = 32'd3373259426;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_MUL1,
    ST_CORDIC,
    ST_DIV2,
    ST_MUL2,
    ST_OUT
  } state_e;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd843314857;
      5'd1:  r = 32'd497837829;
      5'd2:  r = 32'd263043837;
      5'd3:  r = 32'd133525159;
      5'd4:  r = 32'd67021687;
      5'd5:  r = 32'd33543516;
      5'd6:  r = 32'd16775851;
      5'd7:  r = 32'd8388437;
      5'd8:  r = 32'd4194283;
      5'd9:  r = 32'd2097149;
      5'd31: r = 32'd0;
      default: r = 32'd1 << (5'd30 - idx);
    endcase
    return r;
  endfunction

endpackage

### rtl/tpt_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload of width W under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpt_stream_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/tpt_one_pole_multimode_filter.sv
// ----------------------------------------------------------------------------
// One-pole multimode filter
// Trapezoidal one-pole filter with lowpass, highpass and allpass outputs.
// ----------------------------------------------------------------------------
// A sample with an unchanged cutoff passes only the bit-serial multiplier; a
// new cutoff or a rate write first runs the serial dividers, the phase
// multiplier and the CORDIC iterations.
// Throughput: one transaction at a time; the next is accepted once the result
// is taken and no configuration write is pending. Reset clears the state, the coefficient and the cutoff.
module tpt_one_pole_multimode_filter #(
  parameter int unsigned SAMPLE_BITS  = 24,
  parameter int unsigned STATE_BITS   = 32,
  parameter int unsigned COEF_BITS    = 24,
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  tpt_stream_if.sink   cfg_i,
  tpt_stream_if.sink   in_i,
  tpt_stream_if.source out_o
);
  localparam int unsigned CB = tpt_pkg::CutoffBits;
  localparam int unsigned RB = tpt_pkg::RateBits;
  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned DW = STATE_BITS + 2;
  localparam int unsigned MW = DW + COEF_BITS;

  tpt_pkg::state_e state_q, state_d;
  logic [RB-1:0] rate_q;
  logic [CB-1:0] last_q;
  logic [COEF_BITS-1:0] gain_q;
  logic signed [STATE_BITS-1:0] integ_q;
  logic signed [SB-1:0] x_q;
  logic ret_idle_q;
  logic [6:0] cnt_q;
  logic [63:0] num_q;
  logic [33:0] rem_q;
  logic [33:0] dvs_q;
  logic [31:0] quo_q;
  logic [63:0] acc_q;
  logic [31:0] mpl_q;
  logic signed [32:0] cx_q, cy_q, cz_q;
  logic neg_q;
  logic [MW-1:0] macc_q;
  logic [DW-1:0] mmc_q;
  logic [COEF_BITS-1:0] mg_q;
  logic out_valid_q;
  logic [3*SB-1:0] out_data_q;

  logic [RB-1:0] sr_eff;
  logic [CB-1:0] fmax, fcl;
  logic [34:0] rem_sh, rem_sub;
  logic signed [32:0] dxs, dys;
  logic signed [DW-1:0] diff;
  logic signed [DW+1:0] v, lp, hp, ap, s2;
  logic [31:0] qfin, mcand;
  logic in_ok, cfg_ok;
  logic [4:0] ci;

  function automatic logic signed [SB-1:0] sat_s(input logic signed [DW+1:0] a);
    logic signed [DW+1:0] hi, lo;
    hi = (DW+2)'((64'sd1 <<< (SB-1)) - 1);
    lo = -hi - 1;
    if (a > hi) return hi[SB-1:0];
    if (a < lo) return lo[SB-1:0];
    return a[SB-1:0];
  endfunction

  // The quotient including the bit decided by the current compare.
  function automatic logic [31:0] quo_fix(input logic [31:0] q, input logic [34:0] rs);
    return {q[30:0], ~rs[34]};
  endfunction

  assign sr_eff = (rate_q == '0) ? RB'(1) : rate_q;
  assign fmax   = CB'((sr_eff - RB'(1)) >> 1);
  assign fcl    = (last_q > fmax) ? fmax : last_q;
  assign ci     = cnt_q[4:0];
  assign dxs    = cy_q >>> ci;
  assign dys    = cx_q >>> ci;

  assign rem_sh  = {rem_q, num_q[63]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign qfin    = quo_fix(quo_q, rem_sub);
  assign mcand   = (cnt_q == 7'd0) ? qfin : quo_q;

  assign in_ok  = in_i.valid && in_i.ready;
  assign cfg_ok = cfg_i.valid && cfg_i.ready;
  assign in_i.ready  = (state_q == tpt_pkg::ST_IDLE) && !out_valid_q && !cfg_i.valid;
  assign cfg_i.ready = (state_q == tpt_pkg::ST_IDLE) && !out_valid_q;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign diff = DW'(x_q) - DW'(integ_q);
  assign v  = neg_q ? -$signed({2'b00, macc_q[MW-1:COEF_BITS]})
                    : $signed({2'b00, macc_q[MW-1:COEF_BITS]});
  assign lp = v + (DW+2)'(integ_q);
  assign s2 = v + lp;
  assign hp = (DW+2)'(x_q) - lp;
  assign ap = lp - hp;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tpt_pkg::ST_IDLE: begin
        if (cfg_ok) state_d = tpt_pkg::ST_DIV1;
        else if (in_ok) begin
          if (in_i.data[3*0+SB +: CB] != last_q) state_d = tpt_pkg::ST_DIV1;
          else state_d = tpt_pkg::ST_MUL2;
        end
      end
      tpt_pkg::ST_DIV1:   if (cnt_q == 7'd63) state_d = tpt_pkg::ST_MUL1;
      tpt_pkg::ST_MUL1:   if (cnt_q == 7'd31) state_d = tpt_pkg::ST_CORDIC;
      tpt_pkg::ST_CORDIC: if (cnt_q == 7'(CORDIC_STEPS - 1)) state_d = tpt_pkg::ST_DIV2;
      tpt_pkg::ST_DIV2: begin
        if (cnt_q == 7'(COEF_BITS + 32)) begin
          state_d = ret_idle_q ? tpt_pkg::ST_IDLE : tpt_pkg::ST_MUL2;
        end
      end
      tpt_pkg::ST_MUL2:   if (cnt_q == 7'(DW - 1)) state_d = tpt_pkg::ST_OUT;
      tpt_pkg::ST_OUT:    state_d = tpt_pkg::ST_IDLE;
      default:            state_d = tpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpt_pkg::ST_IDLE;
      rate_q      <= tpt_pkg::RateReset;
      last_q      <= '0;
      gain_q      <= '0;
      integ_q     <= '0;
      x_q         <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      cnt_q       <= '0;
      ret_idle_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_o.valid && out_o.ready) out_valid_q <= 1'b0;
      if (state_d != state_q) cnt_q <= '0;
      else cnt_q <= cnt_q + 7'd1;
      case (state_q)
        tpt_pkg::ST_IDLE: begin
          if (cfg_ok) begin
            rate_q     <= cfg_i.data[RB-1:0];
            ret_idle_q <= 1'b1;
          end else if (in_ok) begin
            x_q        <= in_i.data[SB-1:0];
            last_q     <= in_i.data[SB +: CB];
            ret_idle_q <= 1'b0;
          end
        end
        tpt_pkg::ST_DIV2: begin
          if (cnt_q == 7'(COEF_BITS + 32)) begin
            if ((cx_q + cy_q) == '0) gain_q <= '0;
            else if (qfin > 32'((64'd1 << COEF_BITS) - 1)) gain_q <= '1;
            else gain_q <= qfin[COEF_BITS-1:0];
          end
        end
        tpt_pkg::ST_OUT: begin
          integ_q     <= (s2 > (DW+2)'((64'sd1 <<< (STATE_BITS-1)) - 1)) ?
                         {1'b0, {(STATE_BITS-1){1'b1}}} :
                         (s2 < -(DW+2)'(64'sd1 <<< (STATE_BITS-1))) ?
                         {1'b1, {(STATE_BITS-1){1'b0}}} : s2[STATE_BITS-1:0];
          out_valid_q <= 1'b1;
          out_data_q  <= {sat_s(ap), sat_s(hp), sat_s(lp)};
        end
        default: ;
      endcase
    end
  end

  // Datapath registers for the serial units.
  always_ff @(posedge clk_i) begin
    case (state_q)
      tpt_pkg::ST_IDLE: begin
        num_q <= '0;
        rem_q <= '0;
        quo_q <= '0;
        macc_q <= '0;
        acc_q <= '0;
        if (in_ok) begin
          neg_q <= 1'b0;
        end
      end
      tpt_pkg::ST_DIV1: begin
        if (cnt_q == 7'd0) begin
          num_q <= {15'd0, fcl, 32'd0};
          rem_q <= '0;
          dvs_q <= 34'(sr_eff);
        end else begin
          if (!rem_sub[34]) begin
            rem_q <= rem_sub[33:0];
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rem_sh[33:0];
            quo_q <= {quo_q[30:0], 1'b0};
          end
          num_q <= {num_q[62:0], 1'b0};
        end
        acc_q <= '0;
        mpl_q <= tpt_pkg::PiQ30;
      end
      tpt_pkg::ST_MUL1: begin
        // One bit of the phase product per cycle, least significant first.
        acc_q <= {1'b0, acc_q[63:1]} + (mpl_q[0] ? {1'b0, mcand, 31'd0} : 64'd0);
        mpl_q <= {1'b0, mpl_q[31:1]};
        if (cnt_q == 7'd0) quo_q <= qfin;
        if (cnt_q == 7'd31) begin
          cx_q <= 33'sd1 <<< 29;
          cy_q <= '0;
        end
      end
      tpt_pkg::ST_CORDIC: begin
        begin
          logic signed [32:0] z;
          z = (cnt_q == 7'd0) ? $signed({1'b0, acc_q[63:32]}) : cz_q;
          if (!z[32]) begin
            cx_q <= cx_q - dxs;
            cy_q <= cy_q + dys;
            cz_q <= z - $signed({1'b0, tpt_pkg::atan_q30(ci)});
          end else begin
            cx_q <= cx_q + dxs;
            cy_q <= cy_q - dys;
            cz_q <= z + $signed({1'b0, tpt_pkg::atan_q30(ci)});
          end
        end
      end
      tpt_pkg::ST_DIV2: begin
        if (cnt_q == 7'd0) begin
          if (cx_q[32]) cx_q <= '0;
          if (cy_q[32]) cy_q <= '0;
          num_q <= '0;
          rem_q <= '0;
          quo_q <= '0;
        end else if (cnt_q == 7'd1) begin
          num_q <= {cy_q[30:0], 33'd0};
          dvs_q <= 34'(cx_q) + 34'(cy_q);
        end else begin
          if (!rem_sub[34]) begin
            rem_q <= rem_sub[33:0];
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rem_sh[33:0];
            quo_q <= {quo_q[30:0], 1'b0};
          end
          num_q <= {num_q[62:0], 1'b0};
        end
      end
      tpt_pkg::ST_MUL2: begin
        if (cnt_q == 7'd0) begin
          neg_q  <= diff[DW-1];
          mmc_q  <= diff[DW-1] ? DW'(-diff) : DW'(diff);
          mg_q   <= gain_q;
          macc_q <= '0;
        end else begin
          macc_q <= macc_q + (mmc_q[0] ? ({{DW{1'b0}}, mg_q} << (cnt_q - 7'd1)) : '0);
          mmc_q  <= {1'b0, mmc_q[DW-1:1]};
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/tpt_checker.sv
// ----------------------------------------------------------------------------
// Port checker for the one-pole multimode filter
// Watches handshakes on the ports of the top level.
// ----------------------------------------------------------------------------
module tpt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_valid,
  input logic cfg_ready
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("accepted while result pending");
  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
  a_cfg_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid && cfg_ready |=> !out_valid) else $error("result after config");
endmodule

bind tpt_one_pole_multimode_filter tpt_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .cfg_valid(cfg_i.valid), .cfg_ready(cfg_i.ready)
);
